// ===== rtl/core/spectrum_to_chroma_vector_assert.svh =====
// assertion macros for the chroma vector block
// no dependencies
`ifndef SPECTRUM_TO_CHROMA_VECTOR_ASSERT_SVH
`define SPECTRUM_TO_CHROMA_VECTOR_ASSERT_SVH
// implication checked at every edge outside reset
`define STC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define STC_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/stc_pkg.sv =====
// shared types and constants for the chroma vector block
// no dependencies
`timescale 1ns / 1ps
package stc_pkg;
  localparam int unsigned FftSize = 4096;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned NumClasses = 12;
  localparam int unsigned SumW = 38;
  localparam int unsigned TallyW = 13;
  localparam int unsigned AvgW = 24;
  localparam int unsigned RegW = 13;

  localparam logic ActLoad = 1'b0;
  localparam logic ActSample = 1'b1;
  localparam logic [1:0] RegLowBin = 2'd0;
  localparam logic [1:0] RegHighBin = 2'd1;

  typedef struct packed {
    logic        action;
    logic [11:0] bin_index;
    logic signed [23:0] real_part;
    logic signed [23:0] imag_part;
    logic [3:0]  pitch_class;
    logic        frame_last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  chroma_index;
    logic [23:0] average_energy;
    logic        empty_class;
    logic        last_of_frame;
  } out_item_t;

  // one finished class handed from front to back
  typedef struct packed {
    logic [3:0]        cls;
    logic [SumW-1:0]   sum;
    logic [TallyW-1:0] tally;
  } div_job_t;

  typedef enum logic [1:0] {StIdle, StSqrt, StAcc, StDump} front_state_e;
  typedef enum logic [1:0] {DvIdle, DvRun, DvOut} div_state_e;
endpackage

// ===== rtl/core/spectrum_to_chroma_vector.sv =====
// sample item: two squaring multiplies, 25 square-root steps, accumulate; no new item is taken meanwhile
// load item: taken while idle; frame end holds the input until the 4-deep divider
// queue has taken all 12 class sums
// each result comes from the one-bit-per-cycle divider in the back end, which takes no new job until done
// reset: rst_ni async active low clears sums, tallies and control; the class map is not cleared
`timescale 1ns / 1ps
module spectrum_to_chroma_vector (
  input  logic clk_i,
  input  logic rst_ni,
  input  stc_pkg::in_item_t in_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output stc_pkg::out_item_t out_data_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import stc_pkg::*;
  `include "spectrum_to_chroma_vector_assert.svh"

  logic [RegW-1:0] low_bin_q, high_bin_q;
  div_job_t job_f, job_b;
  logic jv_f, jr_f, jv_b, jr_b;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bin_q <= RegW'(1);
      high_bin_q <= RegW'(4096);
    end else if (wr_en) begin
      if (paddr[2] == RegLowBin[0]) low_bin_q <= pwdata[RegW-1:0];
      else high_bin_q <= pwdata[RegW-1:0];
    end
  end

  always_comb begin
    case (paddr[2])
      RegLowBin[0]: prdata = 32'(low_bin_q);
      RegHighBin[0]: prdata = 32'(high_bin_q);
      default: prdata = '0;
    endcase
  end

  stc_front u_front (
    .clk_i, .rst_ni, .in_i(in_data_i), .in_valid_i, .in_ready_o,
    .low_bin_i(low_bin_q), .high_bin_i(high_bin_q),
    .job_o(job_f), .job_valid_o(jv_f), .job_ready_i(jr_f)
  );

  stc_fifo #(.Depth(4)) u_fifo (
    .clk_i, .rst_ni, .wr_data_i(job_f), .wr_valid_i(jv_f), .wr_ready_o(jr_f),
    .rd_data_o(job_b), .rd_valid_o(jv_b), .rd_ready_i(jr_b)
  );

  stc_back u_back (
    .clk_i, .rst_ni, .job_i(job_b), .job_valid_i(jv_b), .job_ready_o(jr_b),
    .out_o(out_data_o), .out_valid_o, .out_ready_i
  );

  `STC_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, out_valid_o && out_data_o.empty_class,
                  out_data_o.average_energy == '0)
  `STC_ASSERT_IMP(a_last_cls, clk_i, rst_ni, out_valid_o && out_data_o.last_of_frame,
                  out_data_o.chroma_index == 4'd11)
  `STC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(out_data_o))
endmodule

// ===== rtl/core/stc_front.sv =====
// front: map memory, magnitude by bit-serial square root, per-class sums
// depends on stc_pkg
`timescale 1ns / 1ps
module stc_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  stc_pkg::in_item_t in_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [stc_pkg::RegW-1:0] low_bin_i,
  input  logic [stc_pkg::RegW-1:0] high_bin_i,
  output stc_pkg::div_job_t job_o,
  output logic job_valid_o,
  input  logic job_ready_i
);
  import stc_pkg::*;
  localparam int unsigned AddrW = $clog2(FftSize);
  localparam int unsigned SqW = 2 * SampleBits + 1;
  localparam int unsigned RootW = SampleBits + 1;
  localparam int unsigned StepW = $clog2(RootW + 1);

  front_state_e state_q, state_d;
  logic [3:0] class_map [FftSize];
  logic [3:0] map_rd_q;
  logic in_range_q, last_q;
  logic [SampleBits-1:0] re_q, im_q;
  logic [RootW-1:0] root_q, root_d;
  logic [StepW-1:0] step_q, step_d;
  logic [1:0] phase_q, phase_d;
  logic [SqW-1:0] sq_q;
  logic [SumW-1:0] sum_q [NumClasses];
  logic [TallyW-1:0] tally_q [NumClasses];
  logic [3:0] dump_q, dump_d;
  logic acc_en, clr_en;

  logic [SampleBits-1:0] abs_re, abs_im;
  logic [11:0] bin_w;
  logic [RegW:0] bin_ext;
  logic in_range;
  logic accept;
  logic [SumW:0] sum_add;

  assign accept = in_valid_i && in_ready_o;
  assign bin_w = in_i.bin_index;
  assign bin_ext = (RegW + 1)'(bin_w);
  assign in_range = (32'(bin_w) < FftSize) && (bin_ext >= {1'b0, low_bin_i})
                    && (bin_ext < {1'b0, high_bin_i});
  assign abs_re = in_i.real_part[SampleBits-1] ? -in_i.real_part[SampleBits-1:0]
                                                : in_i.real_part[SampleBits-1:0];
  assign abs_im = in_i.imag_part[SampleBits-1] ? -in_i.imag_part[SampleBits-1:0]
                                                : in_i.imag_part[SampleBits-1:0];

  always_ff @(posedge clk_i) begin
    if (accept && in_i.action == ActLoad && 32'(bin_w) < FftSize) begin
      class_map[bin_w[AddrW-1:0]] <= in_i.pitch_class;
    end
    if (accept) begin
      map_rd_q <= class_map[bin_w[AddrW-1:0]];
      re_q <= abs_re;
      im_q <= abs_im;
      in_range_q <= in_range;
      last_q <= in_i.frame_last;
    end
  end

  // square sum in two multiplies, then one root bit per cycle
  logic [SqW-1:0] sq_part;
  assign sq_part = (phase_q == 2'd0) ? SqW'(re_q) * SqW'(re_q) : SqW'(im_q) * SqW'(im_q);

  // restoring square root: remainder and root on two bits of input per step
  logic [2*RootW-1:0] rad_q, rad_d;
  logic [RootW+1:0] r_shift, r_trial;
  logic [RootW+1:0] rr_q, rr_d;
  assign r_shift = {rr_q[RootW-1:0], rad_q[2*RootW-1 -: 2]};
  assign r_trial = r_shift - {root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    step_d = step_q;
    root_d = root_q;
    rr_d = rr_q;
    rad_d = rad_q;
    dump_d = dump_q;
    acc_en = 1'b0;
    clr_en = 1'b0;
    in_ready_o = 1'b0;
    job_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (accept && in_i.action == ActSample) begin
          state_d = StSqrt;
          phase_d = 2'd0;
          step_d = '0;
        end
      end
      StSqrt: begin
        if (phase_q == 2'd0) begin
          phase_d = 2'd1;
        end else if (phase_q == 2'd1) begin
          phase_d = 2'd2;
        end else begin
          if (step_q == 0) begin
            rad_d = (2 * RootW)'(sq_q);
            rr_d = '0;
            root_d = '0;
            step_d = step_q + 1'b1;
          end else begin
            if (!r_trial[RootW+1]) begin
              rr_d = r_trial;
              root_d = {root_q[RootW-2:0], 1'b1};
            end else begin
              rr_d = r_shift;
              root_d = {root_q[RootW-2:0], 1'b0};
            end
            rad_d = {rad_q[2*RootW-3:0], 2'b00};
            if (32'(step_q) == RootW) begin
              state_d = StAcc;
            end else begin
              step_d = step_q + 1'b1;
            end
          end
        end
      end
      StAcc: begin
        acc_en = 1'b1;
        if (last_q) begin
          state_d = StDump;
          dump_d = '0;
        end else begin
          state_d = StIdle;
        end
      end
      StDump: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          if (32'(dump_q) == NumClasses - 1) begin
            clr_en = 1'b1;
            state_d = StIdle;
          end else begin
            dump_d = dump_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSqrt && phase_q == 2'd0) sq_q <= sq_part;
    if (state_q == StSqrt && phase_q == 2'd1) sq_q <= sq_q + sq_part;
    rad_q <= rad_d;
    rr_q <= rr_d;
  end

  assign sum_add = {1'b0, sum_q[map_rd_q]} + (SumW + 1)'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= '0;
      step_q <= '0;
      root_q <= '0;
      dump_q <= '0;
      for (int k = 0; k < NumClasses; k++) begin
        sum_q[k] <= '0;
        tally_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      step_q <= step_d;
      root_q <= root_d;
      dump_q <= dump_d;
      if (clr_en) begin
        for (int k = 0; k < NumClasses; k++) begin
          sum_q[k] <= '0;
          tally_q[k] <= '0;
        end
      end else if (acc_en && in_range_q && 32'(map_rd_q) < NumClasses) begin
        sum_q[map_rd_q] <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
        if (tally_q[map_rd_q] != {TallyW{1'b1}}) begin
          tally_q[map_rd_q] <= tally_q[map_rd_q] + 1'b1;
        end
      end
    end
  end

  assign job_o.cls = dump_q;
  assign job_o.sum = sum_q[dump_q];
  assign job_o.tally = tally_q[dump_q];
endmodule

// ===== rtl/core/stc_fifo.sv =====
// short queue of class jobs between front and back
// depends on stc_pkg
`timescale 1ns / 1ps
module stc_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  stc_pkg::div_job_t wr_data_i,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  output stc_pkg::div_job_t rd_data_o,
  output logic rd_valid_o,
  input  logic rd_ready_i
);
  import stc_pkg::*;
  localparam int unsigned PtrW = $clog2(Depth);
  div_job_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != (PtrW + 1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (32'(wp_q) == Depth - 1) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (32'(rp_q) == Depth - 1) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW + 1)'(wr) - (PtrW + 1)'(rd);
    end
  end
endmodule

// ===== rtl/core/stc_back.sv =====
// back: radix-2 restoring divider, one quotient bit per cycle, output register
// depends on stc_pkg
`timescale 1ns / 1ps
module stc_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  stc_pkg::div_job_t job_i,
  input  logic job_valid_i,
  output logic job_ready_o,
  output stc_pkg::out_item_t out_o,
  output logic out_valid_o,
  input  logic out_ready_i
);
  import stc_pkg::*;
  localparam int unsigned CntW = $clog2(SumW + 1);

  div_state_e state_q, state_d;
  logic [SumW-1:0] quo_q;
  logic [TallyW:0] rem_q;
  logic [TallyW-1:0] den_q;
  logic [3:0] cls_q;
  logic [CntW-1:0] cnt_q;
  logic [TallyW:0] rem_sh, rem_sub;
  logic load, step;

  assign rem_sh = {rem_q[TallyW-1:0], quo_q[SumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    job_ready_o = 1'b0;
    load = 1'b0;
    step = 1'b0;
    case (state_q)
      DvIdle: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          load = 1'b1;
          state_d = DvRun;
        end
      end
      DvRun: begin
        step = 1'b1;
        if (32'(cnt_q) == SumW - 1) state_d = DvOut;
      end
      DvOut: begin
        if (!out_valid_o || out_ready_i) state_d = DvIdle;
      end
      default: state_d = DvIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quo_q <= job_i.sum;
      den_q <= job_i.tally;
      cls_q <= job_i.cls;
      rem_q <= '0;
    end else if (step) begin
      if (!rem_sub[TallyW]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DvIdle;
      cnt_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= load ? '0 : (step ? cnt_q + 1'b1 : cnt_q);
      if (state_q == DvOut && (!out_valid_o || out_ready_i)) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DvOut && (!out_valid_o || out_ready_i)) begin
      out_o.chroma_index <= cls_q;
      out_o.empty_class <= den_q == '0;
      out_o.last_of_frame <= 32'(cls_q) == NumClasses - 1;
      if (den_q == '0) out_o.average_energy <= '0;
      else if (quo_q[SumW-1:AvgW] != '0) out_o.average_energy <= {AvgW{1'b1}};
      else out_o.average_energy <= quo_q[AvgW-1:0];
    end
  end
endmodule
